// File: rtl/pcfm_pkg.sv
// Package for the channel failover manager: request/result structs, config
// struct, codes, state encoding and the chain-count clamp.
// No dependencies.
package pcfm_pkg;

	// Channels reachable through the request fields and masks
	localparam int IO_CHANNELS  = 4;
	localparam int NUM_CH_DEF   = 4;
	// Chain order registers hold eight 3-bit entries
	localparam int CHAIN_SLOTS  = 8;
	localparam int ENTRY_W      = 3;
	localparam int CNT_W        = 4;
	localparam int MAX_CHAIN    = 8;
	localparam int CHAIN_MAX    = (MAX_CHAIN < CHAIN_SLOTS) ? MAX_CHAIN : CHAIN_SLOTS;
	localparam int CODE_W       = 16;
	localparam int TIME_W       = 32;
	localparam int FAIL_W       = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [CODE_W-1:0] CODE_OK_LOW  = 16'd200;
	localparam logic [CODE_W-1:0] CODE_OK_HIGH = 16'd300;
	localparam logic [FAIL_W-1:0] FAIL_LIMIT   = 8'd3;
	localparam logic [FAIL_W-1:0] FAIL_SAT     = 8'd255;

	localparam logic [TIME_W-1:0] WDOG_RESET   = 32'd60000;
	localparam logic [TIME_W-1:0] RECOV_RESET  = 32'd300000;

	typedef enum logic [1:0] {
		REQ_SEND       = 2'd0,
		REQ_TICK       = 2'd1,
		REQ_MARK_ALIVE = 2'd2,
		REQ_MARK_DEAD  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		OUT_SENT       = 2'd0,
		OUT_BACKUP     = 2'd1,
		OUT_ALL_FAILED = 2'd2,
		OUT_NOT_SEND   = 2'd3
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORDER_PRIMARY = 3'd0,
		CFG_COUNT_PRIMARY = 3'd1,
		CFG_ORDER_LEGACY  = 3'd2,
		CFG_COUNT_LEGACY  = 3'd3,
		CFG_RECOV_ENABLE  = 3'd4,
		CFG_ENABLE_MASK   = 3'd5,
		CFG_WDOG_TIMEOUT  = 3'd6,
		CFG_RECOV_IVAL    = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_TICK,
		ST_REC,
		ST_MARK,
		ST_DONE
	} seq_state_t;

	typedef logic [CHAIN_SLOTS-1:0][ENTRY_W-1:0] chain_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [TIME_W-1:0]        now_ms;
		logic [1:0]               channel;
		logic signed [CODE_W-1:0] code_ch0;
		logic signed [CODE_W-1:0] code_ch1;
		logic signed [CODE_W-1:0] code_ch2;
		logic signed [CODE_W-1:0] code_ch3;
		logic [IO_CHANNELS-1:0]   handler_mask;
		logic                     backup_ok;
	} req_t;

	typedef struct packed {
		logic [1:0]             outcome;
		logic [1:0]             used_channel;
		logic [IO_CHANNELS-1:0] alive_mask;
		logic [2:0]             active_count;
	} result_t;

	typedef struct packed {
		logic [CHAIN_SLOTS*ENTRY_W-1:0] order_primary;
		logic [CNT_W-1:0]               count_primary;
		logic [CHAIN_SLOTS*ENTRY_W-1:0] order_legacy;
		logic [CNT_W-1:0]               count_legacy;
		logic                           recovery_enable;
		logic [IO_CHANNELS-1:0]         enable_mask;
		logic [TIME_W-1:0]              watchdog_timeout;
		logic [TIME_W-1:0]              recovery_interval;
	} cfg_t;

	// Per-lane commands from the sequencer, one active at a time
	typedef struct packed {
		logic try_en;
		logic wd_en;
		logic mark_alive;
		logic mark_dead;
		logic rec_clr;
	} lane_cmd_t;

	typedef struct packed {
		logic alive;
		logic ok;
	} lane_sts_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (n > CNT_W'(CHAIN_MAX)) r = CNT_W'(CHAIN_MAX);
		return r;
	endfunction

endpackage

// File: rtl/pcfm_lane.sv
// One channel lane: alive flag, fail count and last-success time, with the
// status-code check and the watchdog compare for that channel.
// Depends on pcfm_pkg.
module pcfm_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pcfm_pkg::lane_cmd_t              cmd,
	input  logic [pcfm_pkg::CODE_W-1:0]      code,
	input  logic [pcfm_pkg::TIME_W-1:0]      now,
	input  logic                             enabled,
	input  logic [pcfm_pkg::TIME_W-1:0]      timeout,
	output pcfm_pkg::lane_sts_t              sts
);
	import pcfm_pkg::*;

	logic              alive_q;
	logic [FAIL_W-1:0] fail_q;
	logic [TIME_W-1:0] last_ok_q;

	logic              code_ok;
	logic [FAIL_W-1:0] fail_inc;
	logic              wd_expired;

	// 2xx codes count as delivered; negative codes fall above the window
	assign code_ok  = (code >= CODE_OK_LOW) && (code < CODE_OK_HIGH);
	assign fail_inc = (fail_q == FAIL_SAT) ? fail_q : fail_q + FAIL_W'(1);

	// Watchdog: alive, enabled, last-success time nonzero, silent too long
	assign wd_expired = enabled && alive_q && (last_ok_q != '0) &&
		((now - last_ok_q) > timeout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q   <= 1'b0;
			fail_q    <= '0;
			last_ok_q <= '0;
		end else begin
			priority if (cmd.try_en) begin
				if (code_ok) begin
					alive_q   <= 1'b1;
					last_ok_q <= now;
					fail_q    <= '0;
				end else begin
					fail_q <= fail_inc;
					if (fail_inc >= FAIL_LIMIT) alive_q <= 1'b0;
				end
			end else if (cmd.wd_en) begin
				if (wd_expired) alive_q <= 1'b0;
			end else if (cmd.mark_alive) begin
				alive_q   <= 1'b1;
				last_ok_q <= now;
				fail_q    <= '0;
			end else if (cmd.mark_dead) begin
				alive_q <= 1'b0;
			end else if (cmd.rec_clr) begin
				if (!alive_q) fail_q <= '0;
			end
		end
	end

	assign sts.alive = alive_q;
	assign sts.ok    = code_ok;

endmodule

// File: rtl/pcfm_seq.sv
// Sequencer and merge stage: walks the chain order one entry per cycle,
// steers commands to the lanes, runs the tick/recovery steps, forms outcome.
// Depends on pcfm_pkg.
module pcfm_seq #(
	parameter int NUM_CHANNELS = pcfm_pkg::NUM_CH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic [1:0]                            req_type,
	input  pcfm_pkg::req_t                        req_q,
	input  pcfm_pkg::cfg_t                        cfg,
	input  pcfm_pkg::lane_sts_t [((NUM_CHANNELS < pcfm_pkg::IO_CHANNELS) ?
		NUM_CHANNELS : pcfm_pkg::IO_CHANNELS)-1:0] sts,
	output pcfm_pkg::lane_cmd_t [((NUM_CHANNELS < pcfm_pkg::IO_CHANNELS) ?
		NUM_CHANNELS : pcfm_pkg::IO_CHANNELS)-1:0] cmd,
	output logic                                  busy,
	output logic                                  done,
	output logic [1:0]                            outcome,
	output logic [1:0]                            used_channel
);
	import pcfm_pkg::*;

	localparam int LANES = (NUM_CHANNELS < IO_CHANNELS) ? NUM_CHANNELS : IO_CHANNELS;

	seq_state_t        state_q, state_d;
	req_kind_t         kind_q;
	chain_t            order_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic              sent_q;
	logic [1:0]        used_q;
	logic [TIME_W-1:0] last_rec_q;

	chain_t             idx_order;
	logic [ENTRY_W-1:0] entry;
	logic               at_end;
	logic [LANES-1:0]   sel_vec;
	logic [LANES-1:0]   eligible;
	logic [LANES-1:0]   enab;
	logic [LANES-1:0]   ok_vec;
	logic               success;
	logic               rec_hit;
	logic               rec_due;
	logic               rec_go;

	// Index order used by non-tick requests when neither chain count is set
	always_comb begin
		for (int i = 0; i < CHAIN_SLOTS; i++) idx_order[i] = ENTRY_W'(i);
	end

	// Current chain entry and which lane it selects
	assign entry  = order_q[idx_q[ENTRY_W-1:0]];
	assign at_end = (idx_q == n_q);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sel_vec[i]  = (entry == ENTRY_W'(i));
			enab[i]     = cfg.enable_mask[i];
			eligible[i] = cfg.enable_mask[i] && req_q.handler_mask[i];
			ok_vec[i]   = sts[i].ok;
		end
	end

	assign success = |(sel_vec & eligible & ok_vec);
	assign rec_hit = |(sel_vec & enab);
	assign rec_due = (req_q.now_ms - last_rec_q) > cfg.recovery_interval;
	assign rec_go  = cfg.recovery_enable && (cfg.count_legacy > CNT_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_kind_t'(req_type))
						REQ_SEND:                      state_d = ST_SEND;
						REQ_TICK:                      state_d = ST_TICK;
						REQ_MARK_ALIVE, REQ_MARK_DEAD: state_d = ST_MARK;
					endcase
				end
			end
			ST_SEND: begin
				if (at_end || success) state_d = ST_DONE;
			end
			ST_TICK: begin
				state_d = (rec_due && rec_go) ? ST_REC : ST_DONE;
			end
			ST_REC: begin
				if (at_end || rec_hit) state_d = ST_DONE;
			end
			ST_MARK: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: lane commands, handshake, outcome
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			cmd[i].try_en     = (state_q == ST_SEND) && !at_end && sel_vec[i] && eligible[i];
			cmd[i].wd_en      = (state_q == ST_TICK);
			cmd[i].mark_alive = (state_q == ST_MARK) && (kind_q == REQ_MARK_ALIVE) &&
				(req_q.channel == 2'(i));
			cmd[i].mark_dead  = (state_q == ST_MARK) && (kind_q == REQ_MARK_DEAD) &&
				(req_q.channel == 2'(i));
			cmd[i].rec_clr    = (state_q == ST_REC) && !at_end && sel_vec[i] && enab[i];
		end
		busy         = (state_q != ST_IDLE);
		done         = (state_q == ST_DONE);
		used_channel = used_q;
		if (kind_q != REQ_SEND) outcome = OUT_NOT_SEND;
		else if (sent_q)        outcome = OUT_SENT;
		else if (req_q.backup_ok) outcome = OUT_BACKUP;
		else                    outcome = OUT_ALL_FAILED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Walk registers and recovery timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= REQ_SEND;
			order_q    <= '0;
			n_q        <= '0;
			idx_q      <= '0;
			sent_q     <= 1'b0;
			used_q     <= '0;
			last_rec_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q <= req_kind_t'(req_type);
						idx_q  <= '0;
						sent_q <= 1'b0;
						used_q <= '0;
						if (req_kind_t'(req_type) == REQ_TICK) begin
							order_q <= chain_t'(cfg.order_legacy);
							n_q     <= clamp_count(cfg.count_legacy);
						end else if (cfg.count_primary != '0) begin
							order_q <= chain_t'(cfg.order_primary);
							n_q     <= clamp_count(cfg.count_primary);
						end else if (cfg.count_legacy != '0) begin
							order_q <= chain_t'(cfg.order_legacy);
							n_q     <= clamp_count(cfg.count_legacy);
						end else begin
							order_q <= idx_order;
							n_q     <= CNT_W'(NUM_CHANNELS);
						end
					end
				end
				ST_SEND: begin
					if (!at_end) begin
						if (success) begin
							sent_q <= 1'b1;
							used_q <= entry[1:0];
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				ST_TICK: begin
					if (rec_due) last_rec_q <= req_q.now_ms;
				end
				ST_REC: begin
					if (!at_end) idx_q <= idx_q + CNT_W'(1);
				end
				ST_MARK, ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/priority_chain_failover_manager_unit.sv
// Top level of the channel failover manager: config registers, request
// capture, one lane per channel and the sequencer.
// Depends on pcfm_pkg, pcfm_lane, pcfm_seq.
//
//  channel   signals                      direction  handshake
//  request   start, busy, req             in         taken when start && !busy
//  result    done, result                 out        one-cycle strobe, no stall
//  config    cfg_we, cfg_idx, cfg_wdata   in         written when cfg_we
//
// A request is taken on an idle edge; busy stays high through the cycle that
// carries done, and the next request may be taken at the edge after it.
// Send: states SEND then DONE; the walk tries one chain entry per cycle, at most 8
// entries of a configured chain, until one delivers or the chain runs out.
// Tick: TICK, then REC for a recovery walk when due, then DONE. Mark: MARK, DONE.
// Reset clears all channel state and loads the config reset values.
// The receiver cannot stall results.
module priority_chain_failover_manager_unit #(
	parameter int NUM_CHANNELS = pcfm_pkg::NUM_CH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pcfm_pkg::req_t                    req,
	output logic                              done,
	output pcfm_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [pcfm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pcfm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import pcfm_pkg::*;

	localparam int LANES = (NUM_CHANNELS < IO_CHANNELS) ? NUM_CHANNELS : IO_CHANNELS;

	cfg_t                               cfg_q;
	req_t                               req_q;
	logic                               accept;
	logic [IO_CHANNELS-1:0][CODE_W-1:0] codes;
	lane_cmd_t [LANES-1:0]              cmd;
	lane_sts_t [LANES-1:0]              sts;
	logic [1:0]                         outcome;
	logic [1:0]                         used_channel;
	logic [IO_CHANNELS-1:0]             alive_mask;
	logic [2:0]                         active_count;

	assign accept = start && !busy;

	// Config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order_primary     <= '0;
			cfg_q.count_primary     <= '0;
			cfg_q.order_legacy      <= '0;
			cfg_q.count_legacy      <= '0;
			cfg_q.recovery_enable   <= 1'b0;
			cfg_q.enable_mask       <= '0;
			cfg_q.watchdog_timeout  <= WDOG_RESET;
			cfg_q.recovery_interval <= RECOV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_ORDER_PRIMARY: cfg_q.order_primary <= cfg_wdata[CHAIN_SLOTS*ENTRY_W-1:0];
				CFG_COUNT_PRIMARY: cfg_q.count_primary <= cfg_wdata[CNT_W-1:0];
				CFG_ORDER_LEGACY:  cfg_q.order_legacy  <= cfg_wdata[CHAIN_SLOTS*ENTRY_W-1:0];
				CFG_COUNT_LEGACY:  cfg_q.count_legacy  <= cfg_wdata[CNT_W-1:0];
				CFG_RECOV_ENABLE:  cfg_q.recovery_enable <= cfg_wdata[0];
				CFG_ENABLE_MASK:   cfg_q.enable_mask   <= cfg_wdata[IO_CHANNELS-1:0];
				CFG_WDOG_TIMEOUT:  cfg_q.watchdog_timeout  <= cfg_wdata[TIME_W-1:0];
				CFG_RECOV_IVAL:    cfg_q.recovery_interval <= cfg_wdata[TIME_W-1:0];
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
	end

	assign codes = {req_q.code_ch3, req_q.code_ch2, req_q.code_ch1, req_q.code_ch0};

	// Channel lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pcfm_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd[g]),
			.code    (codes[g]),
			.now     (req_q.now_ms),
			.enabled (cfg_q.enable_mask[g]),
			.timeout (cfg_q.watchdog_timeout),
			.sts     (sts[g])
		);
	end

	pcfm_seq #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req.req_type),
		.req_q        (req_q),
		.cfg          (cfg_q),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.done         (done),
		.outcome      (outcome),
		.used_channel (used_channel)
	);

	// Alive mask and count of enabled alive channels
	always_comb begin
		alive_mask   = '0;
		active_count = '0;
		for (int i = 0; i < LANES; i++) begin
			alive_mask[i] = sts[i].alive;
			active_count  = active_count + 3'(sts[i].alive && cfg_q.enable_mask[i]);
		end
	end

	assign result.outcome      = outcome;
	assign result.used_channel = used_channel;
	assign result.alive_mask   = alive_mask;
	assign result.active_count = active_count;

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after request taken");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result strobe");

	a_sent_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.outcome == OUT_SENT)) |-> result.alive_mask[result.used_channel])
		else $error("delivering channel not alive");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.active_count <= 3'(LANES))
		else $error("active count exceeds channel count");

endmodule
